// ===== hdl/ptt_pkg.sv =====
// package for the priority task timer table: widths, codes, entry type
// no dependencies
`default_nettype none
package ptt_pkg;
  localparam int TASKS = 16;
  localparam int IDX_W = $clog2(TASKS);
  localparam int CNT_W = $clog2(TASKS + 1);
  localparam int MAX_RESULTS = 16;

  localparam logic [1:0] MODE_CREATE = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_INVALID     = 3'd1;
  localparam logic [2:0] ST_FULL        = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
  localparam logic [2:0] ST_NOT_STARTED = 3'd4;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] period;
    logic [15:0] remaining;
    logic        periodic;
  } entry_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  task_id;
    logic [7:0]  priority_req;
    logic [15:0] period;
    logic        periodic;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] status;
    logic [7:0] fired_id;
    logic       last;
  } out_item_t;
endpackage
`default_nettype wire

// ===== hdl/ptt_if.sv =====
// valid/ready channel interfaces for the task timer table
// depends on ptt_pkg
`default_nettype none
interface ptt_in_if (input wire logic clk);
  logic valid;
  logic ready;
  ptt_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ptt_out_if (input wire logic clk);
  logic valid;
  logic ready;
  ptt_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/priority_task_timer_table.sv =====
// top level of the priority task timer table: sequencer around one entry memory
// depends on ptt_pkg and ptt_if
//
//  channel | dir | payload                                        | handshake
//  in_     | in  | mode, task_id, priority_req, period, periodic  | valid/ready
//  out_    | out | kind, status, fired_id, last                   | valid/ready
//
// one item at a time; the entry memory has one read and one write port,
// read data is registered, so the walk waits for each entry's data before the next read.
// create: accept plus id scan, then a shift that writes the new entry at pos and moves the tail up;
// delete: scan plus a shift-down of the tail; tick: one walk over the table, held by output stalls.
// reset clears state, count, started, output valid, pend and held; memory contents need no reset.
// a result waits in the output register; a stalled output holds the walk.
`default_nettype none
module priority_task_timer_table (
  input  wire logic clk,
  input  wire logic rst_n,
  ptt_in_if.sink    in_ch,
  ptt_out_if.source out_ch
);
  import ptt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_TICK  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  // entry memory
  entry_t mem [TASKS];
  entry_t rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic rd_en;
  logic we;
  logic [IDX_W-1:0] wr_addr;
  entry_t wr_data;

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  logic [2:0] state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic started_r, started_nxt;
  in_item_t item_r, item_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;   // read index
  logic [CNT_W-1:0] wr_r, wr_nxt;     // write index (tick compaction, delete shift)
  logic [CNT_W-1:0] pos_r, pos_nxt;   // insert position or found index
  logic found_r, found_nxt;
  logic pos_set_r, pos_set_nxt;
  logic pend_r, pend_nxt;             // read data valid for idx_r-1
  logic [4:0] nout_r, nout_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;
  logic [7:0] held_id_r, held_id_nxt; // fired id awaiting a later one
  logic held_r, held_nxt;
  entry_t carry_r, carry_nxt;         // entry moving during a shift

  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_r;

  wire out_free = !out_valid_r || out_ch.ready;
  entry_t ent;
  entry_t dec;
  logic fire;
  // decremented entry, reloaded with its period when it fires
  always_comb begin
    ent = rd_data_r;
    dec = ent;
    dec.remaining = ent.remaining - 16'd1;
    fire = (dec.remaining == '0);
    if (fire) dec.remaining = ent.period;
  end

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; started_nxt = started_r;
    item_nxt = item_r; idx_nxt = idx_r; wr_nxt = wr_r; pos_nxt = pos_r;
    found_nxt = found_r; pos_set_nxt = pos_set_r; pend_nxt = 1'b0;
    nout_nxt = nout_r; held_id_nxt = held_id_r; held_nxt = held_r;
    carry_nxt = carry_r;
    out_valid_nxt = out_valid_r && !out_ch.ready; out_nxt = out_r;
    rd_en = 1'b0; rd_addr = idx_r[IDX_W-1:0];
    we = 1'b0; wr_addr = wr_r[IDX_W-1:0]; wr_data = ent;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          item_nxt = in_ch.data;
          idx_nxt = '0; wr_nxt = '0; pos_nxt = count_r;
          found_nxt = 1'b0; pos_set_nxt = 1'b0; nout_nxt = '0;
          held_nxt = 1'b0;
          if (in_ch.data.mode == MODE_TICK) state_nxt = S_TICK;
          else if (in_ch.data.mode == MODE_CREATE ||
                   in_ch.data.mode == MODE_DELETE) state_nxt = S_SCAN;
        end
      end
      // scan for id match and insert position
      S_SCAN: begin
        if (pend_r) begin
          if (ent.id == item_r.task_id && !found_r) begin
            found_nxt = 1'b1; pos_nxt = idx_r - 1'b1;
          end
          if (item_r.mode == MODE_CREATE && !pos_set_r &&
              ent.prio > item_r.priority_req) begin
            pos_set_nxt = 1'b1;
            if (!(ent.id == item_r.task_id)) pos_nxt = idx_r - 1'b1;
          end
        end
        if (!pend_r && idx_r < count_r) begin
          rd_en = 1'b1; pend_nxt = 1'b1; idx_nxt = idx_r + 1'b1;
        end else if (!pend_r) begin
          // scan done: decide
          out_nxt.kind = 1'b0; out_nxt.fired_id = '0; out_nxt.last = 1'b1;
          if (item_r.mode == MODE_CREATE) begin
            if (item_r.period == '0 || found_r) out_nxt.status = ST_INVALID;
            else if (count_r == CNT_W'(TASKS)) out_nxt.status = ST_FULL;
            else out_nxt.status = ST_OK;
          end else begin
            if (!started_r) out_nxt.status = ST_NOT_STARTED;
            else if (!found_r) out_nxt.status = ST_NOT_FOUND;
            else out_nxt.status = ST_OK;
          end
          if (out_free) begin
            out_valid_nxt = 1'b1;
            if (out_nxt.status == ST_OK) begin
              state_nxt = S_SHIFT;
              if (item_r.mode == MODE_CREATE) begin
                started_nxt = 1'b1;
                // write new entry at pos, carry old ones upward
                carry_nxt.id = item_r.task_id;
                carry_nxt.prio = item_r.priority_req;
                carry_nxt.period = item_r.period;
                carry_nxt.remaining = item_r.period;
                carry_nxt.periodic = item_r.periodic;
                idx_nxt = pos_r;
                count_nxt = count_r + 1'b1;
              end else begin
                idx_nxt = pos_r + 1'b1;
                wr_nxt = pos_r;
                count_nxt = count_r - 1'b1;
              end
            end else state_nxt = S_IDLE;
          end else out_nxt = out_r;
        end
      end
      // insert: read idx, write carry; delete: read idx, write idx-1
      S_SHIFT: begin
        if (item_r.mode == MODE_CREATE) begin
          if (!pend_r) begin
            if (idx_r < count_r) begin
              if (idx_r < count_r - 1'b1) begin
                rd_en = 1'b1; pend_nxt = 1'b1;
              end
              we = 1'b1; wr_addr = idx_r[IDX_W-1:0]; wr_data = carry_r;
              idx_nxt = idx_r + 1'b1;
              if (!(idx_r < count_r - 1'b1)) state_nxt = S_IDLE;
            end else state_nxt = S_IDLE;
          end else carry_nxt = ent;
          if (pend_r) rd_addr = idx_r[IDX_W-1:0];
          if (!pend_r && idx_r < count_r - 1'b1) rd_addr = idx_r[IDX_W-1:0];
        end else begin
          if (pend_r) begin
            we = 1'b1; wr_addr = wr_r[IDX_W-1:0]; wr_data = ent;
            wr_nxt = wr_r + 1'b1;
          end else if (idx_r <= count_r) begin
            rd_en = 1'b1; pend_nxt = 1'b1; idx_nxt = idx_r + 1'b1;
          end else state_nxt = S_IDLE;
        end
      end
      // tick walk with in-place compaction
      S_TICK: begin
        if (pend_r) begin
          if (fire) begin
            if (nout_r < 5'(MAX_RESULTS)) begin
              held_nxt = 1'b1; held_id_nxt = ent.id;
              nout_nxt = nout_r + 1'b1;
            end
            if (ent.periodic) begin
              we = 1'b1; wr_data = dec; wr_nxt = wr_r + 1'b1;
            end
          end else begin
            we = 1'b1; wr_data = dec; wr_nxt = wr_r + 1'b1;
          end
          // emit the previous held id, now known not last
          if (held_r && fire && nout_r < 5'(MAX_RESULTS)) begin
            out_valid_nxt = 1'b1;
            out_nxt = '{kind: 1'b1, status: ST_OK, fired_id: held_id_r, last: 1'b0};
          end
        end else if (idx_r < count_r) begin
          if (out_free) begin
            rd_en = 1'b1; pend_nxt = 1'b1; idx_nxt = idx_r + 1'b1;
          end
        end else begin
          count_nxt = wr_r;
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!held_r) state_nxt = S_IDLE;
        else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{kind: 1'b1, status: ST_OK, fired_id: held_id_r, last: 1'b1};
          held_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= '0; started_r <= 1'b0;
      out_valid_r <= 1'b0; pend_r <= 1'b0; held_r <= 1'b0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; started_r <= started_nxt;
      out_valid_r <= out_valid_nxt; pend_r <= pend_nxt; held_r <= held_nxt;
    end
    item_r <= item_nxt; idx_r <= idx_nxt; wr_r <= wr_nxt; pos_r <= pos_nxt;
    found_r <= found_nxt; pos_set_r <= pos_set_nxt; nout_r <= nout_nxt;
    held_id_r <= held_id_nxt; carry_r <= carry_nxt; out_r <= out_nxt;
  end
endmodule
`default_nettype wire

// ===== hdl/ptt_checker.sv =====
// port-level checks for the priority task timer table, bound to the top level
// depends on ptt_pkg and ptt_if
`default_nettype none
module ptt_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire ptt_pkg::out_item_t out_data
);
  import ptt_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // status results are always last
  a_stat_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.kind |-> out_data.last)
    else $error("status result not last");

  // fired results carry ok status
  a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind |-> out_data.status == ST_OK)
    else $error("fired result with status");

  // no result in the cycle after an input transfer
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result right after accept");
endmodule

bind priority_task_timer_table ptt_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire

// ===== tb/tb_ptt_if.sv =====
// testbench copy point: the block's channel interfaces are in hdl/ptt_if.sv
// this file holds the timescale and a small utility package for the testbench side
`timescale 1ns / 1ps
package tb_ptt_util_pkg;
  localparam int TB_LATENCY = 80;
endpackage

// ===== tb/tb_priority_task_timer_table.sv =====
// testbench for priority_task_timer_table: create, delete and tick traffic
// checked against an in-bench model of the ordered task table; needs ptt_pkg, ptt_if, tb_ptt_if
`timescale 1ns / 1ps
module tb_priority_task_timer_table;
  import ptt_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ptt_in_if  in_ch (clk);
  ptt_out_if out_ch (clk);

  priority_task_timer_table DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always #4 clk = ~clk;

  // model of the task table
  entry_t    tbl [TASKS];
  int        tbl_cnt;
  bit        tbl_started;
  in_item_t  pending_items [$];
  out_item_t expected_results [$];

  int in_idle_pct, out_idle_pct;
  int mismatches;
  int stall_cycles;

  function automatic int find_task(logic [7:0] id);
    for (int i = 0; i < tbl_cnt; i++)
      if (tbl[i].id == id) return i;
    return -1;
  endfunction

  function automatic out_item_t status_result(logic [2:0] st);
    out_item_t r;
    r.kind = 1'b0;
    r.status = st;
    r.fired_id = 8'd0;
    r.last = 1'b1;
    return r;
  endfunction

  // apply one accepted item to the model and queue the results it causes
  task automatic predict_table(in_item_t it);
    int pos, wr, n, f;
    out_item_t r;
    logic [2:0] st;
    case (it.mode)
      MODE_CREATE: begin
        if (it.period == 16'd0 || find_task(it.task_id) >= 0) st = ST_INVALID;
        else if (tbl_cnt >= TASKS) st = ST_FULL;
        else begin
          pos = 0;
          while (pos < tbl_cnt && tbl[pos].prio <= it.priority_req) pos++;
          for (int i = tbl_cnt; i > pos; i--) tbl[i] = tbl[i-1];
          tbl[pos].id = it.task_id;
          tbl[pos].prio = it.priority_req;
          tbl[pos].period = it.period;
          tbl[pos].remaining = it.period;
          tbl[pos].periodic = it.periodic;
          tbl_cnt++;
          tbl_started = 1'b1;
          st = ST_OK;
        end
        expected_results.push_back(status_result(st));
      end
      MODE_DELETE: begin
        f = find_task(it.task_id);
        if (!tbl_started) st = ST_NOT_STARTED;
        else if (f < 0) st = ST_NOT_FOUND;
        else begin
          for (int i = f; i + 1 < tbl_cnt; i++) tbl[i] = tbl[i+1];
          tbl_cnt--;
          st = ST_OK;
        end
        expected_results.push_back(status_result(st));
      end
      MODE_TICK: begin
        wr = 0;
        n = 0;
        for (int rd = 0; rd < tbl_cnt; rd++) begin
          bit keep;
          keep = 1'b1;
          tbl[rd].remaining = tbl[rd].remaining - 16'd1;
          if (tbl[rd].remaining == 16'd0) begin
            if (n < MAX_RESULTS) begin
              r.kind = 1'b1;
              r.status = ST_OK;
              r.fired_id = tbl[rd].id;
              r.last = 1'b0;
              expected_results.push_back(r);
              n++;
            end
            if (tbl[rd].periodic) tbl[rd].remaining = tbl[rd].period;
            else keep = 1'b0;
          end
          if (keep) begin
            tbl[wr] = tbl[rd];
            wr++;
          end
        end
        tbl_cnt = wr;
        if (n > 0) expected_results[$].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  function automatic in_item_t make_item(logic [1:0] m, logic [7:0] id, logic [7:0] pr,
                                         logic [15:0] per, logic pm);
    in_item_t it;
    it.mode = m;
    it.task_id = id;
    it.priority_req = pr;
    it.period = per;
    it.periodic = pm;
    return it;
  endfunction

  // driver: present queued items, idle at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_table(in_ch.data);
      if (!in_ch.valid || in_ch.ready) begin
        if (in_ch.valid && in_ch.ready) void'(pending_items.pop_front());
        if (pending_items.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.data <= pending_items[0];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: receiver stalls and result checking
  always @(posedge clk) begin
    out_item_t exp_r, got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got.kind !== exp_r.kind || got.status !== exp_r.status ||
              got.fired_id !== exp_r.fired_id || got.last !== exp_r.last) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 20000) begin
      $display("tb_priority_task_timer_table failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  // random traffic: mostly creates and ticks on a small id pool
  task automatic add_random(int count);
    logic [15:0] per;
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      per = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6));
      if ($urandom_range(19) == 0) per = 16'd0;
      if (r < 35)
        pending_items.push_back(make_item(MODE_CREATE, 8'($urandom_range(23)),
                                          8'($urandom_range(4) * 60), per, 1'($urandom)));
      else if (r < 50)
        pending_items.push_back(make_item(MODE_DELETE, 8'($urandom_range(23)), 8'($urandom),
                                          16'($urandom), 1'($urandom)));
      else if (r < 53)
        pending_items.push_back(make_item(MODE_CREATE, 8'($urandom), 8'($urandom),
                                          16'($urandom), 1'($urandom)));
      else if (r < 55)
        pending_items.push_back(make_item(2'd3, 8'($urandom), 8'($urandom),
                                          16'($urandom), 1'($urandom)));
      else
        pending_items.push_back(make_item(MODE_TICK, 8'($urandom), 8'($urandom),
                                          16'($urandom), 1'($urandom)));
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    tbl_cnt = 0;
    tbl_started = 1'b0;
    mismatches = 0;
    stall_cycles = 0;
    in_idle_pct = 34;
    out_idle_pct = 87;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: delete before start, bad creates, ordering, full table, overflow
    pending_items.push_back(make_item(MODE_DELETE, 8'd5, 8'd0, 16'd0, 1'b0));
    pending_items.push_back(make_item(MODE_TICK, 8'd0, 8'd0, 16'd0, 1'b0));
    pending_items.push_back(make_item(2'd3, 8'hff, 8'hff, 16'hffff, 1'b1));
    pending_items.push_back(make_item(MODE_CREATE, 8'd1, 8'd0, 16'd0, 1'b1));
    for (int i = 0; i < 16; i++)
      pending_items.push_back(make_item(MODE_CREATE, 8'(i * 17), 8'(255 - (i % 3) * 127),
                                        (i == 15) ? 16'hffff : 16'd1, 1'(i % 2)));
    pending_items.push_back(make_item(MODE_CREATE, 8'd0, 8'd9, 16'd3, 1'b0));
    pending_items.push_back(make_item(MODE_CREATE, 8'd200, 8'd9, 16'd3, 1'b0));
    pending_items.push_back(make_item(MODE_DELETE, 8'd201, 8'd0, 16'd0, 1'b0));
    pending_items.push_back(make_item(MODE_DELETE, 8'd255, 8'd0, 16'd0, 1'b0));
    pending_items.push_back(make_item(MODE_TICK, 8'd0, 8'd0, 16'd0, 1'b0));
    pending_items.push_back(make_item(MODE_TICK, 8'd0, 8'd0, 16'd0, 1'b0));
    add_random(32);
    wait_drained();
    in_idle_pct = 87;
    out_idle_pct = 34;
    add_random(32);
    wait_drained();
    in_idle_pct = 0;
    out_idle_pct = 0;
    add_random(32);
    wait_drained();
    repeat (tb_ptt_util_pkg::TB_LATENCY) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("tb_priority_task_timer_table passed");
    else
      $display("tb_priority_task_timer_table failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/ptt_pkg.sv
hdl/ptt_if.sv
hdl/priority_task_timer_table.sv
hdl/ptt_checker.sv
tb/tb_ptt_if.sv
tb/tb_priority_task_timer_table.sv
